// File: design/qrs_pkg.sv
// ============================================================================
// qrs_pkg
// Shared constants and types for the quadratic root solver pipeline.
// ============================================================================
package qrs_pkg;

  // default coefficient width (two's complement)
  localparam int COEF_WIDTH_DEF = 32;

  // root format: signed Q32.32
  localparam int ROOT_FRAC  = 32;
  localparam int ROOT_WIDTH = 2 * ROOT_FRAC;

  // zero tolerance register
  localparam int             TOL_WIDTH = 16;
  localparam logic [15:0]    TOL_RESET = 16'd1;

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  // solve mode, chosen before the square root
  localparam logic [1:0] MODE_FIXED  = 2'd0;  // count known, no roots
  localparam logic [1:0] MODE_LINEAR = 2'd1;  // x1 = -c/b
  localparam logic [1:0] MODE_DOUBLE = 2'd2;  // x1 = x2 = -b/2a
  localparam logic [1:0] MODE_TWO    = 2'd3;  // (-b +/- sqrt(d))/2a

  // control that travels beside the dividers
  typedef struct packed {
    logic [1:0] count;
    logic       use1;
    logic       use2;
    logic       dbl;
    logic       neg1;
    logic       neg2;
    logic       over1;
    logic       over2;
  } qrs_side_t;

endpackage

// File: design/quadratic_root_solver.sv
// ============================================================================
// quadratic_root_solver
// Fully pipelined solver of a*x^2 + b*x + c = 0 with fixed-point
// coefficients, giving a root count and two saturated Q32.32 roots.
// ============================================================================
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------
//  input    | in_coef_a, in_coef_b, in_coef_c         | start && !busy
//  result   | out_root_count, out_root_first/_second, | out_valid, one cycle
//           | out_saturated                           |
//  config   | cfg_wdata (zero tolerance)              | cfg_we
//
// One transaction enters every cycle; busy is always low.
// The pipeline holds four front stages, COEF_WIDTH + 1 square root stages
// (one root bit each), one setup stage, 64 divider stages (one quotient bit
// each) and the output register.
// Synchronous active-low reset clears all valid bits; the tolerance resets to 1.
// The receiver cannot stall, so the pipeline never holds.

module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COEF_WIDTH-1:0]     in_coef_a,
  input  logic signed [COEF_WIDTH-1:0]     in_coef_b,
  input  logic signed [COEF_WIDTH-1:0]     in_coef_c,
  input  logic                             cfg_we,
  input  logic [qrs_pkg::TOL_WIDTH-1:0]    cfg_wdata,
  output logic                             out_valid,
  output logic [1:0]                       out_root_count,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_first,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_second,
  output logic                             out_saturated
);

  localparam int W    = COEF_WIDTH;
  localparam int TOLW = qrs_pkg::TOL_WIDTH;
  localparam int QF   = qrs_pkg::ROOT_FRAC;
  localparam int OW   = qrs_pkg::ROOT_WIDTH;
  localparam int SW   = W + 1;       // root bits
  localparam int TW   = 2 * SW;      // discriminant / remainder bits
  localparam int DNW  = W + 1;       // divisor and numerator bits
  localparam int PW   = DNW + OW;    // divider partial remainder + quotient
  localparam int DV   = OW;          // divider stages

  typedef struct packed {
    logic [1:0]   mode;
    logic [1:0]   count;
    logic         an;
    logic         bn;
    logic         cn;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
  } sq_side_t;

  assign busy = 1'b0;

  // zero tolerance register, zero acts as one
  logic [TOLW-1:0] tol_r, tol_eff;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qrs_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end
  assign tol_eff = (tol_r == '0) ? TOLW'(1) : tol_r;

  // stage 1: capture the transaction
  logic         p1_vld_r;
  logic [W-1:0] p1_a_r, p1_b_r, p1_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else        p1_vld_r <= start && !busy;
  end
  always_ff @(posedge clk) begin
    p1_a_r <= in_coef_a;
    p1_b_r <= in_coef_b;
    p1_c_r <= in_coef_c;
  end

  // stage 2: sign and magnitude, near-zero tests
  logic [W-1:0] am_nxt, bm_nxt, cm_nxt;
  assign am_nxt = p1_a_r[W-1] ? (~p1_a_r + W'(1)) : p1_a_r;
  assign bm_nxt = p1_b_r[W-1] ? (~p1_b_r + W'(1)) : p1_b_r;
  assign cm_nxt = p1_c_r[W-1] ? (~p1_c_r + W'(1)) : p1_c_r;

  logic         p2_vld_r, p2_an_r, p2_bn_r, p2_cn_r;
  logic         p2_az_r, p2_bz_r, p2_cz_r;
  logic [W-1:0] p2_am_r, p2_bm_r, p2_cm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p2_vld_r <= 1'b0;
    else        p2_vld_r <= p1_vld_r;
  end
  always_ff @(posedge clk) begin
    p2_an_r <= p1_a_r[W-1];
    p2_bn_r <= p1_b_r[W-1];
    p2_cn_r <= p1_c_r[W-1];
    p2_am_r <= am_nxt;
    p2_bm_r <= bm_nxt;
    p2_cm_r <= cm_nxt;
    p2_az_r <= {{TOLW{1'b0}}, am_nxt} < {{W{1'b0}}, tol_eff};
    p2_bz_r <= {{TOLW{1'b0}}, bm_nxt} < {{W{1'b0}}, tol_eff};
    p2_cz_r <= {{TOLW{1'b0}}, cm_nxt} < {{W{1'b0}}, tol_eff};
  end

  // stage 3: products b*b and a*c
  logic           p3_vld_r;
  logic [2*W-1:0] p3_b2_r, p3_ac_r;
  sq_side_t       p3_side_r;
  logic           p3_az_r, p3_bz_r, p3_cz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p3_vld_r <= 1'b0;
    else        p3_vld_r <= p2_vld_r;
  end
  always_ff @(posedge clk) begin
    p3_b2_r         <= p2_bm_r * p2_bm_r;
    p3_ac_r         <= p2_am_r * p2_cm_r;
    p3_az_r         <= p2_az_r;
    p3_bz_r         <= p2_bz_r;
    p3_cz_r         <= p2_cz_r;
    p3_side_r.mode  <= qrs_pkg::MODE_FIXED;
    p3_side_r.count <= qrs_pkg::CNT_NONE;
    p3_side_r.an    <= p2_an_r;
    p3_side_r.bn    <= p2_bn_r;
    p3_side_r.cn    <= p2_cn_r;
    p3_side_r.am    <= p2_am_r;
    p3_side_r.bm    <= p2_bm_r;
    p3_side_r.cm    <= p2_cm_r;
  end

  // discriminant and solve mode
  logic [TW-1:0] b2x, ac4x, d_nxt;
  logic          dneg, dsmall;
  sq_side_t      side_nxt;
  always_comb begin
    b2x  = {2'b00, p3_b2_r};
    ac4x = {p3_ac_r, 2'b00};
    dneg = 1'b0;
    if ((p3_side_r.an != p3_side_r.cn) && (p3_side_r.cm != '0)) begin
      d_nxt = b2x + ac4x;
    end else if (b2x >= ac4x) begin
      d_nxt = b2x - ac4x;
    end else begin
      d_nxt = ac4x - b2x;
      dneg  = 1'b1;
    end
    dsmall   = d_nxt < {{(TW-TOLW){1'b0}}, tol_eff};
    side_nxt = p3_side_r;
    if (p3_az_r) begin
      if (p3_bz_r) begin
        side_nxt.mode  = qrs_pkg::MODE_FIXED;
        side_nxt.count = p3_cz_r ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
      end else begin
        side_nxt.mode = qrs_pkg::MODE_LINEAR;
      end
    end else if (dneg) begin
      side_nxt.mode  = qrs_pkg::MODE_FIXED;
      side_nxt.count = qrs_pkg::CNT_NONE;
    end else if (dsmall) begin
      side_nxt.mode = qrs_pkg::MODE_DOUBLE;
    end else begin
      side_nxt.mode = qrs_pkg::MODE_TWO;
    end
  end

  // square root pipeline, one root bit per stage
  logic          sq_vld_r  [0:SW];
  logic [TW-1:0] sq_rem_r  [0:SW];
  logic [SW-1:0] sq_root_r [0:SW];
  sq_side_t      sq_side_r [0:SW];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else        sq_vld_r[0] <= p3_vld_r;
  end
  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= d_nxt;
    sq_root_r[0] <= '0;
    sq_side_r[0] <= side_nxt;
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int J = SW - 1 - k;
    logic [TW-1:0] trial;
    logic          take;
    assign trial = ({{(TW-SW){1'b0}}, sq_root_r[k]} << (J + 1)) + (TW'(1) << (2 * J));
    assign take  = sq_rem_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k+1] <= 1'b0;
      else        sq_vld_r[k+1] <= sq_vld_r[k];
    end
    always_ff @(posedge clk) begin
      sq_rem_r[k+1]  <= take ? (sq_rem_r[k] - trial) : sq_rem_r[k];
      sq_root_r[k+1] <= take ? (sq_root_r[k] | (SW'(1) << J)) : sq_root_r[k];
      sq_side_r[k+1] <= sq_side_r[k];
    end
  end

  // numerators, divisors and signs for the two quotients
  sq_side_t           fs;
  logic [DNW-1:0]     bmx, sx, pm, nm, num1, num2, den1, den2, a2;
  logic               mb, pn, nn;
  qrs_pkg::qrs_side_t dside_nxt;
  always_comb begin
    fs  = sq_side_r[SW];
    sx  = sq_root_r[SW];
    bmx = {1'b0, fs.bm};
    a2  = {fs.am, 1'b0};
    mb  = !fs.bn && (fs.bm != '0);
    // -b + s
    if (!mb)            begin pn = 1'b0; pm = bmx + sx; end
    else if (sx >= bmx) begin pn = 1'b0; pm = sx - bmx; end
    else                begin pn = 1'b1; pm = bmx - sx; end
    // -b - s
    if (mb)             begin nn = 1'b1; nm = bmx + sx; end
    else if (bmx >= sx) begin nn = 1'b0; nm = bmx - sx; end
    else                begin nn = 1'b1; nm = sx - bmx; end

    num1 = pm;
    den1 = a2;
    num2 = nm;
    den2 = a2;
    dside_nxt       = '0;
    dside_nxt.neg2  = nn ^ fs.an;
    case (fs.mode)
      qrs_pkg::MODE_LINEAR: begin
        num1            = {1'b0, fs.cm};
        den1            = bmx;
        dside_nxt.neg1  = !fs.cn ^ fs.bn;
        dside_nxt.count = qrs_pkg::CNT_ONE;
        dside_nxt.use1  = 1'b1;
      end
      qrs_pkg::MODE_DOUBLE: begin
        num1            = bmx;
        dside_nxt.neg1  = !fs.bn ^ fs.an;
        dside_nxt.count = qrs_pkg::CNT_ONE;
        dside_nxt.use1  = 1'b1;
        dside_nxt.dbl   = 1'b1;
      end
      qrs_pkg::MODE_TWO: begin
        dside_nxt.neg1  = pn ^ fs.an;
        dside_nxt.count = qrs_pkg::CNT_TWO;
        dside_nxt.use1  = 1'b1;
        dside_nxt.use2  = 1'b1;
      end
      default: begin
        dside_nxt.count = fs.count;
      end
    endcase
  end

  // divider entry: dividend is num * 2^32, start with its bits above 2^64
  logic [DNW+QF-1:0] ne1, ne2;
  logic [DNW-1:0]    rem01, rem02;
  assign ne1   = {{QF{1'b0}}, num1};
  assign ne2   = {{QF{1'b0}}, num2};
  assign rem01 = ne1[DNW+QF-1:QF];
  assign rem02 = ne2[DNW+QF-1:QF];

  // quotient too wide for 64 bits when the top part already reaches the divisor
  qrs_pkg::qrs_side_t dside_ov;
  always_comb begin
    dside_ov       = dside_nxt;
    dside_ov.over1 = rem01 >= den1;
    dside_ov.over2 = rem02 >= den2;
  end

  logic               dv_vld_r  [0:DV];
  qrs_pkg::qrs_side_t dv_side_r [0:DV];
  logic [PW-1:0]      dv_p_r    [0:1][0:DV];
  logic [DNW-1:0]     dv_den_r  [0:1][0:DV];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else        dv_vld_r[0] <= sq_vld_r[SW];
  end
  always_ff @(posedge clk) begin
    dv_p_r[0][0]     <= {rem01, ne1[QF-1:0], {QF{1'b0}}};
    dv_p_r[1][0]     <= {rem02, ne2[QF-1:0], {QF{1'b0}}};
    dv_den_r[0][0]   <= den1;
    dv_den_r[1][0]   <= den2;
    dv_side_r[0]     <= dside_ov;
  end

  // restoring divider stages, one quotient bit each
  for (genvar k = 0; k < DV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k+1] <= 1'b0;
      else        dv_vld_r[k+1] <= dv_vld_r[k];
    end
    always_ff @(posedge clk) begin
      dv_side_r[k+1] <= dv_side_r[k];
    end
    for (genvar u = 0; u < 2; u++) begin : g_unit
      logic [DNW:0]   up, upn;
      logic           qb;
      assign up  = dv_p_r[u][k][PW-1:OW-1];
      assign qb  = up >= {1'b0, dv_den_r[u][k]};
      assign upn = qb ? (up - {1'b0, dv_den_r[u][k]}) : up;
      always_ff @(posedge clk) begin
        dv_p_r[u][k+1]   <= {upn[DNW-1:0], dv_p_r[u][k][OW-2:0], qb};
        dv_den_r[u][k+1] <= dv_den_r[u][k];
      end
    end
  end

  // sign, saturation and selection of the roots
  qrs_pkg::qrs_side_t es;
  logic [OW-1:0] q1, q2, lim1, lim2, mag1, mag2, r1, r2;
  logic          s1, s2;
  always_comb begin
    es   = dv_side_r[DV];
    q1   = dv_p_r[0][DV][OW-1:0];
    q2   = dv_p_r[1][DV][OW-1:0];
    lim1 = es.neg1 ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    lim2 = es.neg2 ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    s1   = es.over1 || (q1 > lim1);
    s2   = es.over2 || (q2 > lim2);
    mag1 = s1 ? lim1 : q1;
    mag2 = s2 ? lim2 : q2;
    r1   = es.neg1 ? (~mag1 + OW'(1)) : mag1;
    r2   = es.neg2 ? (~mag2 + OW'(1)) : mag2;
  end

  // output register, one-cycle strobe per transaction
  logic          out_vld_r;
  logic [1:0]    out_cnt_r;
  logic [OW-1:0] out_r1_r, out_r2_r;
  logic          out_sat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= dv_vld_r[DV];
  end
  always_ff @(posedge clk) begin
    out_cnt_r <= es.count;
    out_r1_r  <= es.use1 ? r1 : '0;
    out_r2_r  <= es.use2 ? r2 : (es.dbl ? r1 : '0);
    out_sat_r <= (es.use1 && s1) || (es.use2 && s2);
  end

  assign out_valid       = out_vld_r;
  assign out_root_count  = out_cnt_r;
  assign out_root_first  = out_r1_r;
  assign out_root_second = out_r2_r;
  assign out_saturated   = out_sat_r;

`ifndef NO_ASSERTIONS
  // no roots or infinitely many: both roots zero and no clipping
  a_empty_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_count == qrs_pkg::CNT_NONE ||
                  out_root_count == qrs_pkg::CNT_INF)
    |-> (out_root_first == '0) && (out_root_second == '0) && !out_saturated)
    else $error("roots present for an empty root count");

  // one root: second root is zero (linear) or equals the first (double)
  a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_count == qrs_pkg::CNT_ONE)
    |-> (out_root_second == '0) || (out_root_second == out_root_first))
    else $error("single root with a stray second root");

  // a transaction leaving the dividers shows up as a strobe next cycle
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[DV] |=> out_valid)
    else $error("result strobe lost");

  // reset empties the output strobe
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe during reset");
`endif

endmodule

// File: dv/quadratic_root_solver_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// quadratic_root_solver_tb
// Self-checking bench for the quadratic root solver. Coefficient sets are
// sent with random gaps. A root predictor in the bench computes the
// expected count, roots and clip flag, and every result strobe is checked
// against the oldest expected root set. Covered: directed special cases,
// several tolerance settings, and random crafted and full-width equations.
// ============================================================================
module quadratic_root_solver_tb;

  localparam int CW        = 32;
  localparam int DRAIN     = 120;        // beyond the pipeline latency
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [1:0]  count;
    logic [63:0] first;
    logic [63:0] second;
    logic        sat;
  } roots_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [CW-1:0] in_coef_a, in_coef_b, in_coef_c;
  logic          cfg_we;
  logic [15:0]   cfg_wdata;
  logic          out_valid;
  logic [1:0]    out_root_count;
  logic [63:0]   out_root_first, out_root_second;
  logic          out_saturated;

  roots_t      expected_roots[$];
  logic [15:0] tol_shadow;
  int          errors;
  int          cycles;

  quadratic_root_solver #(.COEF_WIDTH(CW)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_root_count(out_root_count),
    .out_root_first(out_root_first), .out_root_second(out_root_second),
    .out_saturated(out_saturated)
  );

  // clock
  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // split a coefficient into sign and magnitude
  function automatic logic [64:0] sign_mag(input logic [CW-1:0] v);
    logic [63:0] mag;
    mag = v[CW-1] ? (64'd1 << CW) - {32'd0, v} : {32'd0, v};
    return {v[CW-1], mag};
  endfunction

  // truncating Q32.32 quotient with clipping; returns {clipped, value}
  function automatic logic [64:0] q32_quot(input logic nneg, input logic [63:0] nmag,
                                           input logic dneg, input logic [63:0] dmag);
    logic [127:0] q;
    logic [63:0]  lim, mag;
    logic         neg, clip;
    neg  = nneg != dneg;
    q    = ({64'd0, nmag} << 32) / {64'd0, dmag};
    lim  = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    clip = q > {64'd0, lim};
    mag  = clip ? lim : q[63:0];
    return {clip, neg ? -mag : mag};
  endfunction

  // floor square root of the discriminant
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0]  r, t;
    logic [127:0] sq;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      t  = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= v) r = t;
    end
    return r;
  endfunction

  // predicted roots of one equation
  function automatic roots_t solve_roots(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                         input logic [CW-1:0] c);
    roots_t      r;
    logic        an, bn, cn, dneg, mb, pn, nn;
    logic [63:0] am, bm, cm, tol, s, pm, nm;
    logic [127:0] b2, ac4, d;
    logic [64:0] q1, q2;
    {an, am} = sign_mag(a);
    {bn, bm} = sign_mag(b);
    {cn, cm} = sign_mag(c);
    tol = (tol_shadow == 0) ? 64'd1 : {48'd0, tol_shadow};
    r = '0;
    if (am < tol) begin
      if (bm < tol) begin
        r.count = (cm < tol) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
      end else begin
        r.count = qrs_pkg::CNT_ONE;
        q1 = q32_quot(!cn, cm, bn, bm);
        {r.sat, r.first} = q1;
      end
    end else begin
      b2   = {64'd0, bm} * {64'd0, bm};
      ac4  = ({64'd0, am} * {64'd0, cm}) << 2;
      dneg = 1'b0;
      if (an != cn && cm != 0) d = b2 + ac4;
      else if (b2 >= ac4) d = b2 - ac4;
      else begin
        d    = ac4 - b2;
        dneg = 1'b1;
      end
      if (dneg) begin
        r.count = qrs_pkg::CNT_NONE;
      end else if (d < {64'd0, tol}) begin
        r.count  = qrs_pkg::CNT_ONE;
        q1       = q32_quot(!bn, bm, an, am << 1);
        {r.sat, r.first} = q1;
        r.second = r.first;
      end else begin
        s  = floor_sqrt(d);
        mb = !bn && bm != 0;
        if (!mb) begin pn = 0; pm = bm + s; end
        else if (s >= bm) begin pn = 0; pm = s - bm; end
        else begin pn = 1; pm = bm - s; end
        if (mb) begin nn = 1; nm = bm + s; end
        else if (bm >= s) begin nn = 0; nm = bm - s; end
        else begin nn = 1; nm = s - bm; end
        r.count  = qrs_pkg::CNT_TWO;
        q1       = q32_quot(pn, pm, an, am << 1);
        q2       = q32_quot(nn, nm, an, am << 1);
        r.first  = q1[63:0];
        r.second = q2[63:0];
        r.sat    = q1[64] | q2[64];
      end
    end
    return r;
  endfunction

  // send one coefficient transaction after a random gap
  task automatic send_equation(input logic [CW-1:0] a, input logic [CW-1:0] b,
                               input logic [CW-1:0] c);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (busy);
    expected_roots.push_back(solve_roots(a, b, c));
  endtask

  // write the tolerance once the pipeline has drained
  task automatic write_tolerance(input logic [15:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    tol_shadow = value;
  endtask

  // result checker
  always @(posedge clk) begin
    roots_t e;
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result transaction, count %0d", $time, out_root_count);
        errors++;
      end else begin
        e = expected_roots.pop_front();
        if (out_root_count !== e.count) begin
          $display("%0t: root_count exp %0d got %0d", $time, e.count, out_root_count);
          errors++;
        end
        if (out_root_first !== e.first) begin
          $display("%0t: root_first exp %h got %h", $time, e.first, out_root_first);
          errors++;
        end
        if (out_root_second !== e.second) begin
          $display("%0t: root_second exp %h got %h", $time, e.second, out_root_second);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: saturated exp %0d got %0d", $time, e.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("simulation failed");
      $finish;
    end
  end

  // linear, infinite, no-root, double, two-root and clipping cases
  task automatic test_special_cases();
    send_equation(0, 0, 0);
    send_equation(0, 0, 32'd5 << 16);
    send_equation(0, 32'd2 << 16, 32'd6 << 16);
    send_equation(0, 32'd1, 32'h7fff_ffff);
    send_equation(0, 32'h8000_0000, 32'h8000_0000);
    send_equation(32'd1 << 16, 0, -(32'd1 << 16));
    send_equation(32'd1 << 16, 32'd2 << 16, 32'd1 << 16);
    send_equation(32'd1 << 16, 0, 32'd1 << 16);
    send_equation(32'd1, 32'h7fff_ffff, 0);
    send_equation(32'd1, 32'h8000_0000, 0);
    send_equation(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_equation(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_equation(32'h8000_0000, 0, 32'h8000_0000);
    send_equation(-(32'd3 << 16), 32'd4 << 16, 32'd7 << 16);
    send_equation(32'd1, 32'd2, 32'd1);
    send_equation(32'd1, 0, 0);
  endtask

  // tolerance extremes around the thresholds
  task automatic test_tolerance(input logic [15:0] value);
    write_tolerance(value);
    send_equation(0, 0, 0);
    send_equation(value, value, value);
    send_equation(value - 1, value - 1, value - 1);
    send_equation(-value, 32'd1 << 16, -value);
    send_equation(32'd1, 32'd2, 32'd1);
    send_equation(32'd1 << 16, 32'd2 << 16, (32'd1 << 16) + 32'd1);
  endtask

  // random equations, mostly shaped to hit each root branch
  task automatic test_random(input int n);
    logic [CW-1:0] a, b, c;
    int            m, k;
    for (int i = 0; i < n; i++) begin
      a = $urandom; b = $urandom; c = $urandom;
      case ($urandom_range(0, 6))
        0: ;
        1: begin a = $signed($urandom_range(0, 8)) - 4; end
        2: begin
          a = $signed($urandom_range(0, 4)) - 2;
          b = $signed($urandom_range(0, 8)) - 4;
          c = $signed($urandom_range(0, 8)) - 4;
        end
        3: begin
          // perfect square: b = 2km, c = km^2
          k = $urandom_range(1, 2000) * (($urandom_range(0, 1) != 0) ? 1 : -1);
          m = $signed($urandom_range(0, 2000)) - 1000;
          a = k; b = 2 * k * m; c = k * m * m;
        end
        4: begin
          a = $signed($urandom_range(0, 32'h3_ffff)) - 32'h2_0000;
          b = $signed($urandom_range(0, 32'h3f_ffff)) - 32'h20_0000;
          c = $signed($urandom_range(0, 32'h3f_ffff)) - 32'h20_0000;
        end
        5: begin
          a = $signed($urandom_range(0, 6)) - 3;
          b = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        default: begin
          a = $signed($urandom_range(0, 400)) - 200;
          c = $signed($urandom_range(0, 400)) - 200;
        end
      endcase
      send_equation(a, b, c);
    end
  endtask

  initial begin
    start      = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_coef_a  = '0;
    in_coef_b  = '0;
    in_coef_c  = '0;
    tol_shadow = qrs_pkg::TOL_RESET;
    errors     = 0;
    cycles     = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_random(400);
    test_tolerance(16'd0);
    test_random(300);
    test_tolerance(16'hffff);
    test_random(300);
    test_tolerance(16'd100);
    test_random(300);
    test_tolerance(16'd1);
    test_random(100);

    start <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// File: filelist.f
design/qrs_pkg.sv
design/quadratic_root_solver.sv
dv/quadratic_root_solver_tb.sv
